### src/stack_permutation_checker_macros.svh
`ifndef STACK_PERMUTATION_CHECKER_MACROS_SVH
`define STACK_PERMUTATION_CHECKER_MACROS_SVH

// Combinational invariant, checked at every clock edge outside reset.
`define SPC_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Cause in this cycle implies effect in the same cycle.
`define SPC_ASSERT_IMPL(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |-> (effect)) else $error(msg);

// Cause in this cycle implies effect in the next cycle.
`define SPC_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

### src/spc_pkg.sv
package spc_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int CAR_W           = 11;
    localparam int FEED_W          = CAR_W + 1;   // feed may reach car_count + 1

    typedef enum logic [1:0] {
        V_OK         = 2'd0,
        V_IMPOSSIBLE = 2'd1,
        V_OVERFLOW   = 2'd2
    } t_verdict;

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } t_state;

    typedef struct packed {
        logic accept;     // item taken this cycle
        logic push;       // feed next car onto the stack
        logic pop;        // top matched, remove it
        logic fail_imp;   // order impossible
        logic fail_ovf;   // stack overflowed
        logic emit;       // load result register
    } t_dp_cmd;

    typedef struct packed {
        logic failed;     // case already failed
        logic match;      // stack non-empty and top equals wanted car
        logic feed_left;  // cars remain to be fed
        logic full;       // stack at capacity
        logic out_free;   // result register can take a new verdict
    } t_dp_stat;

endpackage

### src/spc_ctrl.sv
module spc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spc_pkg::t_dp_stat i_stat,
    output spc_pkg::t_dp_cmd  o_cmd
);
    import spc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                priority if (!i_stat.failed && !i_stat.match && i_stat.feed_left
                             && !i_stat.full) begin
                    n_state = ST_STEP;
                end else if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_STEP;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_STEP: begin
                priority if (i_stat.failed) begin
                    o_cmd.emit = i_stat.out_free;
                end else if (i_stat.match) begin
                    o_cmd.pop  = i_stat.out_free;
                    o_cmd.emit = i_stat.out_free;
                end else if (i_stat.feed_left && !i_stat.full) begin
                    o_cmd.push = 1'b1;
                end else if (i_stat.feed_left) begin
                    o_cmd.fail_ovf = i_stat.out_free;
                    o_cmd.emit     = i_stat.out_free;
                end else begin
                    o_cmd.fail_imp = i_stat.out_free;
                    o_cmd.emit     = i_stat.out_free;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### src/spc_dp.sv
`include "stack_permutation_checker_macros.svh"

module spc_dp #(
    parameter int STACK_DEPTH = spc_pkg::STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [spc_pkg::CAR_W-1:0] i_cfg_wdata,
    input  logic                     i_first,
    input  logic [spc_pkg::CAR_W-1:0] i_want,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output spc_pkg::t_verdict        o_verdict,
    input  spc_pkg::t_dp_cmd         i_cmd,
    output spc_pkg::t_dp_stat        o_stat
);
    import spc_pkg::*;

    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [FW-1:0] DEPTH_FILL = FW'(STACK_DEPTH);

    logic [CAR_W-1:0]  r_car_count;
    logic [CAR_W-1:0]  r_want;
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     n_fill;
    logic [FEED_W-1:0] r_feed;
    logic [FEED_W-1:0] n_feed;
    logic [CAR_W-1:0]  r_top;
    t_verdict          r_status;
    t_verdict          n_status;
    logic              r_pop_d;
    logic [CAR_W-1:0]  r_rd_data;
    logic [FW-1:0]     below_top;
    logic              r_out_valid;
    t_verdict          r_verdict;
    logic              restart;

    logic [CAR_W-1:0]  mem [STACK_DEPTH];

    assign restart   = i_cmd.accept && i_first;
    assign below_top = r_fill - FW'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_count <= CAR_W'(1);
        end else if (i_cfg_we) begin
            r_car_count <= i_cfg_wdata;
        end
    end

    always_comb begin
        priority if (i_cmd.fail_ovf) begin
            n_status = V_OVERFLOW;
        end else if (i_cmd.fail_imp) begin
            n_status = V_IMPOSSIBLE;
        end else if (restart) begin
            n_status = V_OK;
        end else begin
            n_status = r_status;
        end
    end

    always_comb begin
        priority if (restart) begin
            n_fill = '0;
            n_feed = FEED_W'(1);
        end else if (i_cmd.push) begin
            n_fill = r_fill + FW'(1);
            n_feed = r_feed + FEED_W'(1);
        end else if (i_cmd.pop) begin
            n_fill = r_fill - FW'(1);
            n_feed = r_feed;
        end else begin
            n_fill = r_fill;
            n_feed = r_feed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_feed      <= FEED_W'(1);
            r_status    <= V_OK;
            r_pop_d     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill   <= n_fill;
            r_feed   <= n_feed;
            r_status <= n_status;
            r_pop_d  <= i_cmd.pop;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_want <= i_want;
        end
        if (i_cmd.emit) begin
            r_verdict <= n_status;
        end
        // top is cached; after a pop the entry beneath is read into r_rd_data, then loaded into r_top
        if (i_cmd.push) begin
            r_top <= r_feed[CAR_W-1:0];
        end else if (r_pop_d) begin
            r_top <= r_rd_data;
        end
    end

    // stack memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_fill[AW-1:0]] <= r_feed[CAR_W-1:0];
        end
        r_rd_data <= mem[below_top[AW-1:0]];
    end

    assign o_stat.failed    = (r_status != V_OK);
    assign o_stat.match     = (r_fill != '0) && (r_top == r_want);
    assign o_stat.feed_left = (r_feed <= {1'b0, r_car_count});
    assign o_stat.full      = (r_fill >= DEPTH_FILL);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    `SPC_ASSERT_HOLDS(a_fill_bound, r_fill <= DEPTH_FILL, "stack fill beyond depth")
    `SPC_ASSERT_IMPL(a_push_not_full, i_cmd.push, r_fill < DEPTH_FILL, "push onto full stack")
    `SPC_ASSERT_IMPL(a_pop_nonempty, i_cmd.pop, r_fill != '0, "pop from empty stack")
    `SPC_ASSERT_IMPL(a_emit_free, i_cmd.emit, !r_out_valid || i_out_ready,
                     "result overwritten before taken")
    `SPC_ASSERT_NEXT(a_push_grows, i_cmd.push && !restart, r_fill == $past(r_fill) + FW'(1),
                     "fill did not follow push")

endmodule

### src/stack_permutation_checker.sv
// Stack permutation checker. Each input item names the car wanted next at
// the output; cars 1..car_count are fed in order through a single stack and
// each item returns the running verdict for the case (0 still possible,
// 1 order impossible, 2 stack overflowed). tuser marks the first item of a
// case, which empties the stack, restarts the feed at car 1 and clears any
// failure before the item is processed. Each item is taken, then the cars
// that it needs are pushed one by one, then the verdict is decided. The
// push loop is bound by the single write port of the stack RAM, one car a
// cycle; each car is pushed at most once per case. Once a case has failed,
// an item is taken and decided with no pushes. The verdict sits in an
// output register, so the next item is taken and worked on while a result
// waits; only the deciding cycle waits for the register to drain. car_count
// may be written only while idle. The stack RAM needs no clearing after
// reset.
module stack_permutation_checker #(
    parameter int STACK_DEPTH = spc_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: car_count
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [10:0] wanted_car, [15:11] zero
    input  logic        i_s_axis_tuser,   // [0] first_of_case
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // [1:0] verdict, [7:2] zero
);
    import spc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    t_verdict verdict;

    // sequencer: take item, step pushes, decide
    spc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // stack RAM, cached top, feed counter, case status, result register
    spc_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_first     (i_s_axis_tuser),
        .i_want      (i_s_axis_tdata[CAR_W-1:0]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_verdict   (verdict),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    assign o_m_axis_tdata = {6'b0, verdict};

endmodule
